/* rtl/i2cm_pkg.sv */
// Shared types and constants of the I2C master bit engine.
// Used by i2cm_front, i2cm_back and i2c_master_bit_engine. No dependencies.
`default_nettype none

package i2cm_pkg;

  // Input mode codes.
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam int unsigned UnitW      = 16;
  localparam int unsigned TickW      = 18;
  localparam int unsigned BitCntW    = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [UnitW-1:0]   UnitTicksReset = 16'd8;
  localparam logic [BitCntW-1:0] BitsPerByte    = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic [23:0] {
    PH_IDLE    = 24'h000001,
    PH_ST_A    = 24'h000002,
    PH_ST_B    = 24'h000004,
    PH_ST_C    = 24'h000008,
    PH_SP_A    = 24'h000010,
    PH_SP_B    = 24'h000020,
    PH_SP_C    = 24'h000040,
    PH_WB_DATA = 24'h000080,
    PH_WB_CLKH = 24'h000100,
    PH_WB_CLKL = 24'h000200,
    PH_WB_GAP  = 24'h000400,
    PH_WB_REL  = 24'h000800,
    PH_WA_SDAH = 24'h001000,
    PH_WA_CLKH = 24'h002000,
    PH_WA_SAMP = 24'h004000,
    PH_WA_CLKL = 24'h008000,
    PH_RB_SDAH = 24'h010000,
    PH_RB_CLKH = 24'h020000,
    PH_RB_REL  = 24'h040000,
    PH_RB_SAMP = 24'h080000,
    PH_RB_CLKL = 24'h100000,
    PH_RB_END  = 24'h200000,
    PH_AK_DATA = 24'h400000,
    PH_AK_CLKH = 24'h800000
  } phase_e;

endpackage

`default_nettype wire

/* rtl/i2cm_front.sv */
// Front end: classifies the mode of each incoming tick and holds it in a short queue.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic [7:0]         write_data_i,
  input  wire logic               send_ack_i,
  input  wire logic               sda_in_i,
  output i2cm_pkg::queue_out_t    q_o,
  input  wire logic               pop_i
);

  i2cm_pkg::item_t                 mem_q [i2cm_pkg::QueueDepth];
  logic [i2cm_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [i2cm_pkg::QCntW-1:0]      count_q, count_d;
  i2cm_pkg::cmd_e                  cmd;
  logic                            push;

  // Codes with no meaning fall through to no command.
  always_comb begin
    case (mode_i)
      i2cm_pkg::MODE_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::MODE_STOP:  cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::MODE_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::MODE_READ:  cmd = i2cm_pkg::CMD_READ;
      default:              cmd = i2cm_pkg::CMD_NONE;
    endcase
  end

  assign in_ready_o = (count_q != i2cm_pkg::QCntW'(i2cm_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == i2cm_pkg::QPtrW'(i2cm_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == i2cm_pkg::QPtrW'(i2cm_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: cmd, write_data: write_data_i,
                           send_ack: send_ack_i, sda_in: sda_in_i};
    end
  end

  assign q_o.valid = (count_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= i2cm_pkg::QCntW'(i2cm_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* rtl/i2cm_back.sv */
// Back end: phase sequencer, tick counter, bit counter and shift register, plus
// the output register that holds one result per tick. Depends on i2cm_pkg.
`default_nettype none

module i2cm_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire i2cm_pkg::queue_out_t         q_i,
  output logic                              pop_o,
  input  wire logic [i2cm_pkg::UnitW-1:0]   unit_ticks_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              scl_level_o,
  output logic                              sda_level_o,
  output logic                              sda_drive_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic                              ack_failed_o,
  output logic [7:0]                        read_data_o
);

  i2cm_pkg::phase_e               phase_q, phase_d, nx;
  logic [i2cm_pkg::TickW-1:0]     tick_q, tick_d;
  logic [i2cm_pkg::BitCntW-1:0]   bit_q, bit_d;
  logic [7:0]                     shift_q, shift_d;
  logic                           ack_q, ack_d;
  logic                           nack_q, nack_d;
  logic                           scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic [7:0]                     last_q, last_d;
  logic                           enter, long_wait, done;
  logic                           out_valid_q;
  logic                           step;
  i2cm_pkg::item_t                it;

  assign it    = q_i.item;
  assign step  = q_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = step;

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    nack_d    = nack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drv_d     = drv_q;
    last_d    = last_q;
    nx        = i2cm_pkg::PH_IDLE;
    enter     = 1'b0;
    long_wait = 1'b0;
    done      = 1'b0;

    if (step) begin
      if (phase_q == i2cm_pkg::PH_IDLE) begin
        case (it.cmd)
          i2cm_pkg::CMD_START: begin
            nx    = i2cm_pkg::PH_ST_A;
            enter = 1'b1;
          end
          i2cm_pkg::CMD_STOP: begin
            nx    = i2cm_pkg::PH_SP_A;
            enter = 1'b1;
          end
          i2cm_pkg::CMD_WRITE: begin
            shift_d = it.write_data;
            bit_d   = '0;
            nx      = i2cm_pkg::PH_WB_DATA;
            enter   = 1'b1;
          end
          i2cm_pkg::CMD_READ: begin
            shift_d = '0;
            bit_d   = '0;
            ack_d   = it.send_ack;
            nx      = i2cm_pkg::PH_RB_SDAH;
            enter   = 1'b1;
          end
          default: ;
        endcase
      end else if (tick_q > i2cm_pkg::TickW'(1)) begin
        tick_d = tick_q - 1'b1;
      end else begin
        enter = 1'b1;
        case (phase_q)
          i2cm_pkg::PH_ST_A:    nx = i2cm_pkg::PH_ST_B;
          i2cm_pkg::PH_ST_B:    nx = i2cm_pkg::PH_ST_C;
          i2cm_pkg::PH_SP_A:    nx = i2cm_pkg::PH_SP_B;
          i2cm_pkg::PH_SP_B:    nx = i2cm_pkg::PH_SP_C;
          i2cm_pkg::PH_WB_DATA: nx = i2cm_pkg::PH_WB_CLKH;
          i2cm_pkg::PH_WB_CLKH: nx = i2cm_pkg::PH_WB_CLKL;
          i2cm_pkg::PH_WB_CLKL: nx = i2cm_pkg::PH_WB_GAP;
          i2cm_pkg::PH_WB_GAP: begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 1'b1;
            nx      = (bit_d >= i2cm_pkg::BitsPerByte) ? i2cm_pkg::PH_WB_REL
                                                       : i2cm_pkg::PH_WB_DATA;
          end
          i2cm_pkg::PH_WB_REL:  nx = i2cm_pkg::PH_WA_SDAH;
          i2cm_pkg::PH_WA_SDAH: nx = i2cm_pkg::PH_WA_CLKH;
          i2cm_pkg::PH_WA_CLKH: nx = i2cm_pkg::PH_WA_SAMP;
          i2cm_pkg::PH_WA_SAMP: nx = i2cm_pkg::PH_WA_CLKL;
          i2cm_pkg::PH_WA_CLKL: begin
            drv_d = 1'b1;
            enter = 1'b0;
          end
          i2cm_pkg::PH_RB_SDAH: nx = i2cm_pkg::PH_RB_CLKH;
          i2cm_pkg::PH_RB_CLKH: nx = i2cm_pkg::PH_RB_REL;
          i2cm_pkg::PH_RB_REL:  nx = i2cm_pkg::PH_RB_SAMP;
          i2cm_pkg::PH_RB_SAMP: nx = i2cm_pkg::PH_RB_CLKL;
          i2cm_pkg::PH_RB_CLKL: begin
            bit_d = bit_q + 1'b1;
            nx    = (bit_d >= i2cm_pkg::BitsPerByte) ? i2cm_pkg::PH_RB_END
                                                     : i2cm_pkg::PH_RB_SDAH;
          end
          i2cm_pkg::PH_RB_END:  nx = i2cm_pkg::PH_AK_DATA;
          i2cm_pkg::PH_AK_DATA: nx = i2cm_pkg::PH_AK_CLKH;
          i2cm_pkg::PH_AK_CLKH: begin
            scl_d  = 1'b0;
            last_d = shift_q;
            enter  = 1'b0;
          end
          default: enter = 1'b0;
        endcase
        if (!enter) begin
          phase_d = i2cm_pkg::PH_IDLE;
          tick_d  = '0;
          done    = 1'b1;
        end
      end

      // Apply the pin action of the phase being entered and load its wait.
      if (enter) begin
        case (nx)
          i2cm_pkg::PH_ST_A: begin
            drv_d = 1'b1;
            sda_d = 1'b1;
            scl_d = 1'b1;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_ST_B: begin
            sda_d = 1'b0;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_ST_C: begin
            scl_d = 1'b0;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_SP_A: begin
            drv_d = 1'b1;
            sda_d = 1'b0;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_SP_B: begin
            scl_d = 1'b1;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_SP_C: begin
            sda_d = 1'b1;
            long_wait = 1'b1;
          end
          i2cm_pkg::PH_WB_DATA: sda_d = shift_d[7];
          i2cm_pkg::PH_WB_CLKH: scl_d = 1'b1;
          i2cm_pkg::PH_WB_CLKL: scl_d = 1'b0;
          i2cm_pkg::PH_WB_REL:  sda_d = 1'b1;
          i2cm_pkg::PH_WA_SDAH: sda_d = 1'b1;
          i2cm_pkg::PH_WA_CLKH: scl_d = 1'b1;
          i2cm_pkg::PH_WA_SAMP: begin
            drv_d  = 1'b0;
            nack_d = it.sda_in;
          end
          i2cm_pkg::PH_WA_CLKL: scl_d = 1'b0;
          i2cm_pkg::PH_RB_SDAH: begin
            drv_d = 1'b1;
            sda_d = 1'b1;
          end
          i2cm_pkg::PH_RB_CLKH: scl_d = 1'b1;
          i2cm_pkg::PH_RB_REL:  drv_d = 1'b0;
          i2cm_pkg::PH_RB_SAMP: shift_d = {shift_q[6:0], it.sda_in};
          i2cm_pkg::PH_RB_CLKL: scl_d = 1'b0;
          i2cm_pkg::PH_RB_END: begin
            drv_d = 1'b1;
            sda_d = 1'b1;
          end
          i2cm_pkg::PH_AK_DATA: begin
            scl_d = 1'b0;
            drv_d = 1'b1;
            sda_d = !ack_q;
          end
          i2cm_pkg::PH_AK_CLKH: scl_d = 1'b1;
          default: ;
        endcase
        phase_d = nx;
        tick_d  = long_wait ? {unit_ticks_i, 2'b00} : {1'b0, unit_ticks_i, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cm_pkg::PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      ack_q       <= 1'b0;
      nack_q      <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
      last_q  <= last_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register; it only loads when the slot is free or being drained.
  always_ff @(posedge clk_i) begin
    if (step) begin
      scl_level_o  <= scl_d;
      sda_level_o  <= sda_d;
      sda_drive_o  <= drv_d;
      busy_res_o   <= (phase_d != i2cm_pkg::PH_IDLE);
      done_res_o   <= done;
      ack_failed_o <= nack_d;
      read_data_o  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  a_idle_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2cm_pkg::PH_IDLE |-> drv_q)
    else $error("SDA released while idle");

  a_wait_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && phase_q != i2cm_pkg::PH_IDLE && tick_q > i2cm_pkg::TickW'(1)
    |=> $stable(phase_q))
    else $error("phase moved during a wait");

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_engine.sv */
// I2C master bit engine: one tick accepted per cycle, and each result is registered
// after its tick has passed through the queue. A two-entry queue feeds the sequencer,
// which holds while its last result waits and advances in the cycle that result is
// transferred out, so the tick input stalls only once the queue is full.
// Reset (rst_ni low, asynchronous) idles the sequencer with SCL and SDA high and
// driven, clears the queue and sets unit_ticks to 8. Depends on i2cm_pkg.
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        send_ack_i,
  input  wire logic        sda_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             sda_drive_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             ack_failed_o,
  output logic [7:0]       read_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [i2cm_pkg::UnitW-1:0] unit_ticks_q;
  i2cm_pkg::queue_out_t       q;
  logic                       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= i2cm_pkg::UnitTicksReset;
    end else if (cfg_we_i) begin
      unit_ticks_q <= cfg_wdata_i;
    end
  end

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .write_data_i (write_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .q_o          (q),
    .pop_i        (pop)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q),
    .pop_o        (pop),
    .unit_ticks_i (unit_ticks_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .ack_failed_o (ack_failed_o),
    .read_data_o  (read_data_o)
  );

endmodule

`default_nettype wire

/* tb/i2cm_pin_checker.sv */
// Checker for the I2C master bit engine: watches the tick and result channels and
// the delay-unit register port, predicts the pin and status word of every tick and
// compares it field by field. Depends on i2cm_pkg.
module i2cm_pin_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        scl_level_i,
  input  logic        sda_level_i,
  input  logic        sda_drive_i,
  input  logic        busy_res_i,
  input  logic        done_res_i,
  input  logic        ack_failed_i,
  input  logic [7:0]  read_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          ticks_due_o,
  output logic        seq_idle_o,
  output int          commands_o
);
  import i2cm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic       nack;
    logic [7:0] rdata;
  } pin_word_t;

  logic [15:0] unit_ticks;
  phase_e      phase;
  logic [17:0] wait_left;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  logic        ack_sel;
  logic        nack_seen;
  logic        scl;
  logic        sda;
  logic        drive;
  logic [7:0]  last_read;

  pin_word_t pin_words_due[$];
  int        mismatches;
  int        commands;
  int        results_seen;

  assign mismatches_o = mismatches;
  assign commands_o   = commands;

  function automatic void reset_engine();
    unit_ticks = UnitTicksReset;
    phase      = PH_IDLE;
    wait_left  = '0;
    bit_idx    = '0;
    shreg      = '0;
    ack_sel    = 1'b0;
    nack_seen  = 1'b0;
    scl        = 1'b1;
    sda        = 1'b1;
    drive      = 1'b1;
    last_read  = '0;
  endfunction

  // Apply the pin action of a phase and load its wait in delay units.
  function automatic void load_phase(phase_e p, logic sda_in);
    int units;
    units = 2;
    case (p)
      PH_ST_A: begin
        drive = 1'b1; sda = 1'b1; scl = 1'b1; units = 4;
      end
      PH_ST_B: begin sda = 1'b0; units = 4; end
      PH_ST_C: begin scl = 1'b0; units = 4; end
      PH_SP_A: begin drive = 1'b1; sda = 1'b0; units = 4; end
      PH_SP_B: begin scl = 1'b1; units = 4; end
      PH_SP_C: begin sda = 1'b1; units = 4; end
      PH_WB_DATA: sda = shreg[7];
      PH_WB_CLKH: scl = 1'b1;
      PH_WB_CLKL: scl = 1'b0;
      PH_WB_REL: sda = 1'b1;
      PH_WA_SDAH: sda = 1'b1;
      PH_WA_CLKH: scl = 1'b1;
      PH_WA_SAMP: begin drive = 1'b0; nack_seen = sda_in; end
      PH_WA_CLKL: scl = 1'b0;
      PH_RB_SDAH: begin drive = 1'b1; sda = 1'b1; end
      PH_RB_CLKH: scl = 1'b1;
      PH_RB_REL: drive = 1'b0;
      PH_RB_SAMP: shreg = {shreg[6:0], sda_in};
      PH_RB_CLKL: scl = 1'b0;
      PH_RB_END: begin drive = 1'b1; sda = 1'b1; end
      PH_AK_DATA: begin scl = 1'b0; drive = 1'b1; sda = !ack_sel; end
      PH_AK_CLKH: scl = 1'b1;
      default: ;
    endcase
    phase     = p;
    wait_left = 18'(units * int'(unit_ticks));
  endfunction

  // Phase after the current one; idle means the command is finished.
  function automatic phase_e follow_phase();
    case (phase)
      PH_ST_A:    return PH_ST_B;
      PH_ST_B:    return PH_ST_C;
      PH_SP_A:    return PH_SP_B;
      PH_SP_B:    return PH_SP_C;
      PH_WB_DATA: return PH_WB_CLKH;
      PH_WB_CLKH: return PH_WB_CLKL;
      PH_WB_CLKL: return PH_WB_GAP;
      PH_WB_GAP: begin
        shreg   = {shreg[6:0], 1'b0};
        bit_idx = bit_idx + 1'b1;
        if (bit_idx >= BitsPerByte) return PH_WB_REL;
        return PH_WB_DATA;
      end
      PH_WB_REL:  return PH_WA_SDAH;
      PH_WA_SDAH: return PH_WA_CLKH;
      PH_WA_CLKH: return PH_WA_SAMP;
      PH_WA_SAMP: return PH_WA_CLKL;
      PH_WA_CLKL: begin
        drive = 1'b1;
        return PH_IDLE;
      end
      PH_RB_SDAH: return PH_RB_CLKH;
      PH_RB_CLKH: return PH_RB_REL;
      PH_RB_REL:  return PH_RB_SAMP;
      PH_RB_SAMP: return PH_RB_CLKL;
      PH_RB_CLKL: begin
        bit_idx = bit_idx + 1'b1;
        if (bit_idx >= BitsPerByte) return PH_RB_END;
        return PH_RB_SDAH;
      end
      PH_RB_END:  return PH_AK_DATA;
      PH_AK_DATA: return PH_AK_CLKH;
      PH_AK_CLKH: begin
        scl       = 1'b0;
        last_read = shreg;
        return PH_IDLE;
      end
      default: return PH_IDLE;
    endcase
  endfunction

  // Advance the engine by one tick and return the pin and status word after it.
  function automatic pin_word_t step_engine(logic [2:0] mode, logic [7:0] wdata,
                                            logic sack, logic sda_in);
    pin_word_t w;
    phase_e    nx;
    logic      fin;
    fin = 1'b0;
    if (phase == PH_IDLE) begin
      case (mode)
        MODE_START: begin
          load_phase(PH_ST_A, sda_in);
          commands++;
        end
        MODE_STOP: begin
          load_phase(PH_SP_A, sda_in);
          commands++;
        end
        MODE_WRITE: begin
          shreg   = wdata;
          bit_idx = '0;
          load_phase(PH_WB_DATA, sda_in);
          commands++;
        end
        MODE_READ: begin
          shreg   = '0;
          bit_idx = '0;
          ack_sel = sack;
          load_phase(PH_RB_SDAH, sda_in);
          commands++;
        end
        default: ;
      endcase
    end else if (wait_left > 18'd1) begin
      wait_left = wait_left - 1'b1;
    end else begin
      nx = follow_phase();
      if (nx == PH_IDLE) begin
        phase     = PH_IDLE;
        wait_left = '0;
        fin       = 1'b1;
      end else begin
        load_phase(nx, sda_in);
      end
    end
    w.scl   = scl;
    w.sda   = sda;
    w.drive = drive;
    w.busy  = (phase != PH_IDLE);
    w.done  = fin;
    w.nack  = nack_seen;
    w.rdata = last_read;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("tick %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pin_word_t want;
    if (!rst_ni) begin
      reset_engine();
      pin_words_due.delete();
      mismatches   = 0;
      commands     = 0;
      results_seen = 0;
      ticks_due_o <= 0;
      seq_idle_o  <= 1'b1;
    end else begin
      if (cfg_we_i) unit_ticks = cfg_wdata_i;
      // A result leaves only after its tick has been queued, so compare before
      // the tick of this edge joins the list.
      if (out_valid_i && out_ready_i) begin
        if (pin_words_due.size() == 0) begin
          report_mismatch($sformatf("result transfer with no tick outstanding"));
        end else begin
          want = pin_words_due.pop_front();
          compare_field("scl_level", scl_level_i, want.scl);
          compare_field("sda_level", sda_level_i, want.sda);
          compare_field("sda_drive", sda_drive_i, want.drive);
          compare_field("busy_res", busy_res_i, want.busy);
          compare_field("done_res", done_res_i, want.done);
          compare_field("ack_failed", ack_failed_i, want.nack);
          compare_field("read_data", read_data_i, want.rdata);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        pin_words_due.push_back(step_engine(mode_i, write_data_i, send_ack_i, sda_in_i));
      end
      ticks_due_o <= pin_words_due.size();
      seq_idle_o  <= (phase == PH_IDLE);
    end
  end

endmodule

/* tb/i2c_master_bit_engine_tb.sv */
// Top of the I2C master bit engine testbench: clock, reset, tick stimulus, result
// drain and verdict. Prediction and comparison live in i2cm_pin_checker.
// Depends on i2cm_pkg, i2c_master_bit_engine and i2cm_pin_checker.
module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  // Mode codes with no command behind them.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_pattern_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [2:0]  mode_i       = MODE_NONE;
  logic [7:0]  write_data_i = '0;
  logic        send_ack_i   = 1'b0;
  logic        sda_in_i     = 1'b1;
  logic        out_ready_i  = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       sda_drive_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       ack_failed_o;
  logic [7:0] read_data_o;

  int   mismatches;
  int   ticks_due;
  int   commands;
  logic seq_idle;

  always #5 clk_i = ~clk_i;

  i2c_master_bit_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .write_data_i(write_data_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .sda_drive_o (sda_drive_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .ack_failed_o(ack_failed_o),
    .read_data_o (read_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  i2cm_pin_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .mode_i      (mode_i),
    .write_data_i(write_data_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_level_i (scl_level_o),
    .sda_level_i (sda_level_o),
    .sda_drive_i (sda_drive_o),
    .busy_res_i  (busy_res_o),
    .done_res_i  (done_res_o),
    .ack_failed_i(ack_failed_o),
    .read_data_i (read_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(mismatches),
    .ticks_due_o (ticks_due),
    .seq_idle_o  (seq_idle),
    .commands_o  (commands)
  );

  // Mostly no pause, some short ones and now and then a long one.
  function automatic int pick_idle(int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  function automatic logic pick_sda(sda_pattern_e pat);
    if (pat == SDA_LOW) return 1'b0;
    if (pat == SDA_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  task automatic send_tick(logic [2:0] mode, logic [7:0] wdata, logic sack, logic sda);
    int gap;
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    write_data_i <= wdata;
    send_ack_i   <= sack;
    sda_in_i     <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = pick_idle(24);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Issue one command and keep ticking until the engine is idle again. With
  // noisy filler, commands are also offered while the engine is busy.
  task automatic run_command(logic [2:0] mode, logic [7:0] wdata, logic sack,
                             sda_pattern_e pat, bit noisy);
    logic [2:0] fill;
    send_tick(mode, wdata, sack, pick_sda(pat));
    do begin
      fill = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom) : MODE_NONE;
      send_tick(fill, 8'($urandom), 1'($urandom), pick_sda(pat));
    end while (!seq_idle);
  endtask

  task automatic set_unit_ticks(logic [15:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ticks_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Start, address byte, one to three data bytes in one direction, stop.
  task automatic run_bus_transaction();
    int  n;
    bit  rd;
    run_command(MODE_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
    run_command(MODE_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
    rd = 1'($urandom);
    n  = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      run_command(rd ? MODE_READ : MODE_WRITE, 8'($urandom), (i < n - 1),
                  SDA_RANDOM, 1'b1);
    end
    run_command(MODE_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b1);
  endtask

  task automatic random_phase(logic [15:0] unit, int n_cmds);
    int goal;
    set_unit_ticks(unit);
    goal = commands + n_cmds;
    while (commands < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        run_bus_transaction();
      end else begin
        repeat ($urandom_range(1, 40)) begin
          send_tick(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  initial begin : result_drain
    int  span;
    int  cycles;
    bit  held;
    cycles = 0;
    held   = 1'b0;
    wait (rst_ni);
    forever begin
      span = $urandom_range(1, 40);
      out_ready_i <= 1'b1;
      repeat (span) @(posedge clk_i);
      cycles += span;
      // One long hold-off so the queue fills and the tick channel backs up.
      if (!held && cycles >= 600) begin
        held = 1'b1;
        span = 400;
      end else begin
        span = pick_idle(40);
      end
      if (span > 0) begin
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
        cycles += span;
      end
    end
  end

  initial begin : tick_source
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The delay unit still holds its reset value here.
    run_command(MODE_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);

    set_unit_ticks(16'd1);
    run_command(MODE_WRITE, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_command(MODE_WRITE, 8'hFF, 1'b1, SDA_HIGH, 1'b0);
    run_command(MODE_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(MODE_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_command(MODE_READ, 8'h3C, 1'b1, SDA_RANDOM, 1'b0);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_command(MODE_RSVD5, 8'hFF, 1'b1, SDA_LOW, 1'b0);
    run_command(MODE_RSVD6, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_command(MODE_RSVD7, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
    run_command(MODE_NONE, 8'h00, 1'b0, SDA_LOW, 1'b0);
    // Commands offered while busy must be ignored.
    run_command(MODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
    run_command(MODE_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 1'b1);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);

    // A zero delay unit makes every wait a single tick.
    set_unit_ticks(16'd0);
    run_command(MODE_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_command(MODE_WRITE, 8'h81, 1'b0, SDA_RANDOM, 1'b0);
    run_command(MODE_READ, 8'h7E, 1'b0, SDA_RANDOM, 1'b0);
    run_command(MODE_STOP, 8'h00, 1'b0, SDA_HIGH, 1'b0);

    random_phase(16'd0, 16);

    // Largest delay unit last: the first wait outlasts the rest of the run.
    set_unit_ticks(16'hFFFF);
    send_tick(MODE_START, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (100) send_tick(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ticks_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && ticks_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
